// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Operation codes, status codes and the shift command sent to the cell row.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Operation codes carried by a request.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_SWAP   = 2'd3;

  // Status codes carried by a result.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NORESULT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Fixed widths of the channel payload.
  localparam int unsigned POS_W   = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_SWP
  } ple_cmd_t;

endpackage

// ----- design/ple_if.sv -----
// ----------------------------------------------------------------------------
// ple_if: request and result channels of the positional list engine
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ple_req_if
  import ple_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [POS_W-1:0]  pos_a;
  logic [POS_W-1:0]  pos_b;
  logic [DATA_W-1:0] value;

  modport source (output valid, output op, output pos_a, output pos_b, output value,
                  input ready);
  modport sink   (input valid, input op, input pos_a, input pos_b, input value,
                  output ready);
endinterface

interface ple_rsp_if
  import ple_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [DATA_W-1:0]  data;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output status, output data, output count,
                  input ready);
  modport sink   (input valid, input status, input data, input count,
                  output ready);
endinterface

// ----- design/ple_cell.sv -----
// ----------------------------------------------------------------------------
// ple_cell: one storage cell of the list row
// Holds one value, takes its left or right neighbor on insert or delete,
// and registers a read tap for each of the two lookup positions.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 6,
  parameter int unsigned W   = 32
) (
  input  logic          clk,
  input  ple_cmd_t      cmd,
  input  logic [IW-1:0] idx_a,
  input  logic [IW-1:0] idx_b,
  input  logic [W-1:0]  ins_val,
  input  logic [W-1:0]  val_a,
  input  logic [W-1:0]  val_b,
  input  logic [W-1:0]  left,
  input  logic [W-1:0]  right,
  output logic [W-1:0]  value,
  output logic [W-1:0]  tap_a,
  output logic [W-1:0]  tap_b
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  // Stored value: shifts with the row on insert and delete, exchanges on swap.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INS: begin
        if (MY_IDX > idx_a) begin
          value <= left;
        end else if (MY_IDX == idx_a) begin
          value <= ins_val;
        end
      end
      CMD_DEL: begin
        if (MY_IDX >= idx_a) begin
          value <= right;
        end
      end
      CMD_SWP: begin
        if (MY_IDX == idx_a) begin
          value <= val_b;
        end else if (MY_IDX == idx_b) begin
          value <= val_a;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

  // Read taps: the value shows only on the cell that is addressed.
  always_ff @(posedge clk) begin
    tap_a <= (MY_IDX == idx_a) ? value : '0;
    tap_b <= (MY_IDX == idx_b) ? value : '0;
  end

endmodule

// ----- design/ple_reduce.sv -----
// ----------------------------------------------------------------------------
// ple_reduce: OR tree that collects the one live tap of the cell row
// Groups of eight taps are OR-ed into registers; the groups are OR-ed last.
// ----------------------------------------------------------------------------
module ple_reduce #(
  parameter int unsigned N = 64,
  parameter int unsigned W = 32
) (
  input  logic                clk,
  input  logic [N-1:0][W-1:0] taps,
  output logic [W-1:0]        result
);

  localparam int unsigned GROUP = 8;
  localparam int unsigned NG    = (N + GROUP - 1) / GROUP;

  logic [NG-1:0][W-1:0] grp_next;
  logic [NG-1:0][W-1:0] grp;

  // First level: OR of each group of eight taps.
  always_comb begin
    grp_next = '0;
    for (int g = 0; g < NG; g++) begin
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < N) begin
          grp_next[g] = grp_next[g] | taps[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
  end

  // Second level: OR across the group registers.
  always_comb begin
    result = '0;
    for (int g = 0; g < NG; g++) begin
      result = result | grp[g];
    end
  end

endmodule

// ----- design/positional_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_core: ordered list held in a row of shifting cells
// Insert, query, delete and swap by position, one result per request.
//
//   channel   modport  transfer        payload
//   request   sink     valid & ready   op, pos_a, pos_b, value
//   result    source   valid & ready   status, data, count
//
// After acceptance each request passes S_TAP, which registers the cell taps,
// S_GRP, which registers the grouped OR tree, and S_EXEC, which applies the
// shift or swap and loads the result register. The row of cells moves every
// entry at once, so insert and delete cost no more than a query. A result
// held by a stalled sink delays the update step; a new request is taken only
// once the engine is back in idle, so requests do not overlap. Reset empties
// the list at once; stored values need no clearing since only positions
// 1..count are read.
// ----------------------------------------------------------------------------
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  ple_req_if.sink   request,
  ple_rsp_if.source result
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TAP,
    S_GRP,
    S_EXEC
  } state_t;

  state_t                  state;
  logic [1:0]              op_q;
  logic [1:0]              st_q;
  logic [IW-1:0]           idx_a;
  logic [IW-1:0]           idx_b;
  logic [VALUE_WIDTH-1:0]  val_q;
  logic [LW-1:0]           length;
  logic [LW-1:0]           length_next;
  logic                    out_valid;
  logic [1:0]              out_status;
  logic [DATA_W-1:0]       out_data;
  logic [COUNT_W-1:0]      out_count;

  logic [CW-1:0]           pa_c;
  logic [CW-1:0]           pb_c;
  logic [CW-1:0]           len_c;
  logic                    pa_ok;
  logic                    pb_ok;
  logic [1:0]              st_new;
  logic                    out_free;
  logic                    do_exec;
  ple_cmd_t                cmd;

  logic [DEPTH-1:0][VALUE_WIDTH-1:0] cell_val;
  logic [DEPTH-1:0][VALUE_WIDTH-1:0] taps_a;
  logic [DEPTH-1:0][VALUE_WIDTH-1:0] taps_b;
  logic [VALUE_WIDTH-1:0]            rd_a;
  logic [VALUE_WIDTH-1:0]            rd_b;

  // Position checks against the current element count.
  always_comb begin
    pa_c  = CW'(request.pos_a);
    pb_c  = CW'(request.pos_b);
    len_c = CW'(length);
    pa_ok = (pa_c != '0) && (pa_c <= len_c);
    pb_ok = (pb_c != '0) && (pb_c <= len_c);
    case (request.op)
      OP_INSERT: begin
        if (pa_c > len_c) begin
          st_new = ST_NORESULT;
        end else if (length == FULL_LEN) begin
          st_new = ST_FULL;
        end else begin
          st_new = ST_DONE;
        end
      end
      OP_SWAP: st_new = (pa_ok && pb_ok) ? ST_DONE : ST_NORESULT;
      default: st_new = pa_ok ? ST_DONE : ST_NORESULT;
    endcase
  end

  // Update step: runs once the result register is free.
  assign out_free = !out_valid || result.ready;
  assign do_exec  = (state == S_EXEC) && out_free;

  always_comb begin
    cmd         = CMD_HOLD;
    length_next = length;
    if (do_exec && st_q == ST_DONE) begin
      case (op_q)
        OP_INSERT: begin
          cmd         = CMD_INS;
          length_next = length + LW'(1);
        end
        OP_DELETE: begin
          cmd         = CMD_DEL;
          length_next = length - LW'(1);
        end
        OP_SWAP:  cmd = CMD_SWP;
        default:  cmd = CMD_HOLD;
      endcase
    end
  end

  // Sequencer, request latch, element count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            state <= S_TAP;
            op_q  <= request.op;
            st_q  <= st_new;
            idx_a <= (request.op == OP_INSERT) ? IW'(pa_c) : IW'(pa_c - CW'(1));
            idx_b <= IW'(pb_c - CW'(1));
            val_q <= VALUE_WIDTH'(request.value);
          end
        end
        S_TAP: state <= S_GRP;
        S_GRP: state <= S_EXEC;
        S_EXEC: begin
          if (out_free) begin
            state      <= S_IDLE;
            length     <= length_next;
            out_valid  <= 1'b1;
            out_status <= st_q;
            out_data   <= (op_q == OP_QUERY && st_q == ST_DONE) ? DATA_W'(rd_a) : '0;
            out_count  <= COUNT_W'(length_next);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign request.ready = (state == S_IDLE);
  assign result.valid  = out_valid;
  assign result.status = out_status;
  assign result.data   = out_data;
  assign result.count  = out_count;

  // Row of cells; each end takes its own value as the missing neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ple_cell #(
      .IDX (i),
      .IW  (IW),
      .W   (VALUE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx_a   (idx_a),
      .idx_b   (idx_b),
      .ins_val (val_q),
      .val_a   (rd_a),
      .val_b   (rd_b),
      .left    ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i - 1]),
      .right   ((i == DEPTH - 1) ? cell_val[i] : cell_val[(i == DEPTH - 1) ? i : i + 1]),
      .value   (cell_val[i]),
      .tap_a   (taps_a[i]),
      .tap_b   (taps_b[i])
    );
  end

  // Read trees for the two addressed positions.
  ple_reduce #(.N(DEPTH), .W(VALUE_WIDTH)) u_read_a (
    .clk    (clk),
    .taps   (taps_a),
    .result (rd_a)
  );

  ple_reduce #(.N(DEPTH), .W(VALUE_WIDTH)) u_read_b (
    .clk    (clk),
    .taps   (taps_b),
    .result (rd_b)
  );

  // The count never exceeds the row size.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= FULL_LEN)
    else $error("element count beyond list depth");

  // An accepted request always starts the tap step.
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> (state == S_TAP))
    else $error("accepted request did not start the sequence");

  // The count only moves in the update step.
  a_len_change: assert property (@(posedge clk) disable iff (rst)
    (length != $past(length)) |-> $past(do_exec))
    else $error("element count changed outside the update step");

  // A full-list status reports a full count.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == ST_FULL) |-> (result.count == COUNT_W'(DEPTH)))
    else $error("full status with a count below depth");

endmodule

// ----- tb/positional_list_engine_core_tb.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb: self-checking bench for the list engine
// Drives insert, query, delete and swap requests through the valid/ready
// request channel and compares every result against an in-bench list model.
// A directed opening covers empty-list and bad-position cases, then random
// rounds fill the list to capacity, push inserts against the full list and
// drain it again, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
  import ple_pkg::*;

  localparam int unsigned      LIST_DEPTH  = 64;
  localparam int               CLK_PERIOD  = 8;
  localparam int               RESET_TICKS = 6;
  localparam int               HOLD_TICKS  = 200;
  localparam int               IDLE_LIMIT  = 2000;
  localparam int               SETTLE      = 10;
  localparam logic [POS_W-1:0] POS_MAX     = '1;

  // Mirror of the stored list; predicts one outcome per accepted request.
  class list_scoreboard;
    typedef struct packed {
      logic [1:0]         status;
      logic [DATA_W-1:0]  data;
      logic [COUNT_W-1:0] count;
    } outcome_t;

    logic [DATA_W-1:0] cells[LIST_DEPTH];
    int unsigned       length;
    outcome_t          outcome_q[$];
    int                errors;
    int                checked;
    int                full_hits;
    int                bad_hits;
    int unsigned       peak_length;

    function new();
      length      = 0;
      errors      = 0;
      checked     = 0;
      full_hits   = 0;
      bad_hits    = 0;
      peak_length = 0;
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function bit pos_ok(logic [POS_W-1:0] p);
      return (p >= 1) && (p <= length);
    endfunction

    // Apply one accepted request to the mirror and queue its outcome.
    function void note_request(logic [1:0] op, logic [POS_W-1:0] pa,
                               logic [POS_W-1:0] pb, logic [DATA_W-1:0] val);
      outcome_t          o;
      logic [DATA_W-1:0] tmp;
      o.status = ST_DONE;
      o.data   = '0;
      case (op)
        OP_INSERT: begin
          if (pa > length) begin
            o.status = ST_NORESULT;
          end else if (length >= LIST_DEPTH) begin
            o.status = ST_FULL;
          end else begin
            for (int i = length; i > pa; i--) cells[i] = cells[i-1];
            cells[pa] = val;
            length++;
          end
        end
        OP_QUERY: begin
          if (!pos_ok(pa)) o.status = ST_NORESULT;
          else o.data = cells[pa-1];
        end
        OP_DELETE: begin
          if (!pos_ok(pa)) begin
            o.status = ST_NORESULT;
          end else begin
            for (int i = pa - 1; i + 1 < length; i++) cells[i] = cells[i+1];
            length--;
          end
        end
        default: begin
          if (!pos_ok(pa) || !pos_ok(pb)) begin
            o.status = ST_NORESULT;
          end else begin
            tmp        = cells[pa-1];
            cells[pa-1] = cells[pb-1];
            cells[pb-1] = tmp;
          end
        end
      endcase
      if (o.status == ST_FULL) full_hits++;
      if (o.status == ST_NORESULT) bad_hits++;
      if (length > peak_length) peak_length = length;
      o.count = length[COUNT_W-1:0];
      outcome_q.push_back(o);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted result with the oldest outstanding outcome.
    task check_result(logic [1:0] status, logic [DATA_W-1:0] data,
                      logic [COUNT_W-1:0] count);
      outcome_t o;
      if (outcome_q.size() == 0) begin
        report("result arrived with no request outstanding");
      end else begin
        o = outcome_q.pop_front();
        checked++;
        if (status !== o.status)
          report($sformatf("status %0d, expected %0d", status, o.status));
        if (data !== o.data)
          report($sformatf("data %08h, expected %08h", data, o.data));
        if (count !== o.count)
          report($sformatf("count %0d, expected %0d", count, o.count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  list_scoreboard list_sb = new();

  bit send_idle_on     = 1'b0;
  bit rsp_idle_on      = 1'b0;
  bit hold_results_req = 1'b0;
  int hold_count       = 0;
  int sent_count       = 0;
  int idle_cycles      = 0;

  positional_list_engine_core #(
    .DEPTH       (LIST_DEPTH),
    .VALUE_WIDTH (DATA_W)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one request and hold it until the engine accepts it.
  task automatic send_request(logic [1:0] op, logic [POS_W-1:0] pa,
                              logic [POS_W-1:0] pb, logic [DATA_W-1:0] val);
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.pos_a <= pa;
    req_ch.pos_b <= pb;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    list_sb.note_request(op, pa, pb, val);
    sent_count++;
  endtask

  // Random gap between requests: mostly none, sometimes short, rarely long.
  task automatic request_gap();
    int r;
    int n;
    r = $urandom_range(99);
    if (send_idle_on && r >= 65) begin
      n = (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering requests until every queued outcome has been checked.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (list_sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly a legal position in lo..hi, sometimes just outside, sometimes any.
  function automatic logic [POS_W-1:0] pick_pos(int lo, int hi);
    int r;
    r = $urandom_range(99);
    if (r < 82 && hi >= lo) return POS_W'($urandom_range(hi, lo));
    if (r < 91) return (lo > 0 && r < 86) ? POS_W'(lo - 1) : POS_W'(hi + 1);
    return POS_W'($urandom_range(POS_MAX));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // One random request with the given insert and delete weights in percent.
  task automatic send_random(int ins_pct, int del_pct);
    int               r;
    logic [1:0]       op;
    logic [POS_W-1:0] pa;
    logic [POS_W-1:0] pb;
    r  = $urandom_range(99);
    pb = POS_W'($urandom_range(POS_MAX));
    if (r < ins_pct) begin
      op = OP_INSERT;
      pa = pick_pos(0, list_sb.length);
    end else if (r < ins_pct + del_pct) begin
      op = OP_DELETE;
      pa = pick_pos(1, list_sb.length);
    end else if (r[0]) begin
      op = OP_QUERY;
      pa = pick_pos(1, list_sb.length);
    end else begin
      op = OP_SWAP;
      pa = pick_pos(1, list_sb.length);
      pb = pick_pos(1, list_sb.length);
    end
    send_request(op, pa, pb, pick_value());
    request_gap();
  endtask

  // Result receiver: random stalls, plus one long hold-off on demand.
  initial begin
    int n;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
        hold_results_req = 1'b0;
        hold_count++;
      end else if (rsp_idle_on && $urandom_range(99) < 30) begin
        n = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Check every accepted result.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      list_sb.check_result(rsp_ch.status, rsp_ch.data, rsp_ch.count);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed cases, random rounds, drain and verdict.
  initial begin
    int guard;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_QUERY;
    req_ch.pos_a <= '0;
    req_ch.pos_b <= '0;
    req_ch.value <= '0;
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;

    // Operations on the empty list, including an insert past the end.
    send_request(OP_QUERY,  0, 0, '0);
    send_request(OP_DELETE, 1, 0, '0);
    send_request(OP_SWAP,   1, 1, '0);
    send_request(OP_INSERT, 1, 0, 32'h0000_0001);
    send_request(OP_INSERT, POS_MAX, POS_MAX, '1);
    // Build a short list at the front, the end and the middle.
    send_request(OP_INSERT, 0, 0, '1);
    send_request(OP_INSERT, 1, 0, '0);
    send_request(OP_INSERT, 0, 0, 32'hA5A5_5A5A);
    send_request(OP_INSERT, 2, 0, 32'h1234_5678);
    for (int p = 0; p <= 5; p++) send_request(OP_QUERY, POS_W'(p), 0, '0);
    send_request(OP_QUERY, POS_MAX, 0, '1);
    // Swaps: legal, with itself, and with either position out of range.
    send_request(OP_SWAP, 1, 4, '0);
    send_request(OP_SWAP, 2, 2, '0);
    send_request(OP_SWAP, 0, 1, '0);
    send_request(OP_SWAP, 1, 5, '0);
    send_request(OP_SWAP, POS_MAX, POS_MAX, '0);
    // Deletes in the middle, at the front and at the end, then bad ones.
    send_request(OP_DELETE, 2, 0, '0);
    send_request(OP_DELETE, 1, 0, '0);
    send_request(OP_DELETE, 2, 0, '0);
    send_request(OP_DELETE, 3, 0, '0);
    send_request(OP_DELETE, 0, 0, '0);
    wait_for_results();

    // Random rounds: fill to capacity, press on the full list, then drain.
    for (int round = 0; round < 5; round++) begin
      send_idle_on = (round != 0);
      rsp_idle_on  = (round != 0);
      if (round == 1) hold_results_req = 1'b1;
      guard = 0;
      while (list_sb.length < LIST_DEPTH && guard < 400) begin
        send_random(75, 10);
        guard++;
      end
      repeat (20) send_random(50, 10);
      if (round == 2) wait_for_results();
      guard = 0;
      while (list_sb.length > 0 && guard < 400) begin
        send_random(10, 70);
        guard++;
      end
      repeat (60) send_random(35, 20);
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d requests and %0d checked results; %0d bad positions.",
             sent_count, list_sb.checked, list_sb.bad_hits);
    $display("List peaked at %0d values, %0d inserts met a full list, %0d long holds.",
             list_sb.peak_length, list_sb.full_hits, hold_count);
    if (list_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
